@@ hw/rtl/rlti_pkg.sv @@
// Shared types and constants for the raster line timing and interrupt block.
// No dependencies; imported by rlti_accum, rlti_raster and the top level.
package rlti_pkg;

	// Item kinds carried on the input tuser
	localparam logic [1:0] OP_ADVANCE = 2'd0;
	localparam logic [1:0] OP_STATUS  = 2'd1;
	localparam logic [1:0] OP_EXT     = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_HINT_RELOAD = 3'd0;
	localparam logic [2:0] REG_HINT_EN     = 3'd1;
	localparam logic [2:0] REG_VINT_EN     = 3'd2;
	localparam logic [2:0] REG_EXT_EN      = 3'd3;
	localparam logic [2:0] REG_DISP_EN     = 3'd4;
	localparam logic [2:0] REG_PAL         = 3'd5;
	localparam logic [2:0] REG_TALL        = 3'd6;
	localparam logic [2:0] REG_INTERLACE   = 3'd7;

	// Field widths
	localparam int CYC_W   = 16;
	localparam int ACC_W   = CYC_W + 1;
	localparam int LINE_W  = 9;
	localparam int VC_W    = 8;
	localparam int STAT_W  = 10;
	localparam int LEVEL_W = 3;

	// Raster constants
	localparam logic [LINE_W-1:0] ACTIVE_SHORT = 9'd224;
	localparam logic [LINE_W-1:0] ACTIVE_TALL  = 9'd240;
	localparam logic [LINE_W-1:0] VC_JUMP      = 9'h0EA;

	// Interrupt levels
	localparam logic [LEVEL_W-1:0] LEVEL_VBLANK = 3'd6;
	localparam logic [LEVEL_W-1:0] LEVEL_HBLANK = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_EXT    = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 3'd0;

	// Status word bit positions
	localparam int ST_FIFO_EMPTY = 9;
	localparam int ST_VINT_SEEN  = 7;
	localparam int ST_ODD        = 4;
	localparam int ST_VBLANK     = 3;
	localparam int ST_PAL        = 0;

	typedef struct packed {
		logic [7:0] hint_reload;
		logic       hint_enable;
		logic       vint_enable;
		logic       ext_enable;
		logic       display_enable;
		logic       pal_mode;
		logic       tall_mode;
		logic       interlace;
	} cfg_t;

	// Commands from the sequencer to the raster state
	typedef struct packed {
		logic step;
		logic status_clear;
		logic ext_set;
	} raster_cmd_t;

	// Raster state seen by the sequencer
	typedef struct packed {
		logic [LEVEL_W-1:0] int_level;
		logic [LINE_W-1:0]  line_number;
		logic [VC_W-1:0]    vcount;
		logic               vblank_flag;
		logic               odd_field;
		logic               vint_seen;
	} raster_view_t;

endpackage

@@ hw/rtl/rlti_accum.sv @@
// Master clock accumulator with the shared compare/subtract unit.
// Depends on rlti_pkg.
module rlti_accum #(
	parameter int CLOCKS_PER_LINE = 3420
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      add,
	input  logic [rlti_pkg::CYC_W-1:0] cycles,
	input  logic                      sub,
	output logic                      line_due
);
	import rlti_pkg::*;

	localparam logic [ACC_W-1:0] CPL = ACC_W'(CLOCKS_PER_LINE);

	logic [ACC_W-1:0] accum_q;

	// One compare per cycle decides whether another full line is banked
	assign line_due = (accum_q >= CPL);

	// Add on a new advance beat, take off one line per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
		end else if (add) begin
			accum_q <= accum_q + ACC_W'(cycles);
		end else if (sub) begin
			accum_q <= accum_q - CPL;
		end
	end

	// A line step is only taken while at least one full line is banked
	a_no_sub_below: assert property (@(posedge clk) disable iff (!arst_n)
		sub |-> line_due)
		else $error("line step taken without a full line banked");

endmodule

@@ hw/rtl/rlti_raster.sv @@
// Scanline counter, vblank/parity tracking, interrupt latches and V readback.
// Depends on rlti_pkg.
module rlti_raster #(
	parameter int LINES_NTSC = 262,
	parameter int LINES_PAL  = 313
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rlti_pkg::cfg_t            cfg,
	input  rlti_pkg::raster_cmd_t     cmd,
	output rlti_pkg::raster_view_t    view
);
	import rlti_pkg::*;

	localparam logic [LINE_W-1:0] TOT_NTSC = LINE_W'(LINES_NTSC);
	localparam logic [LINE_W-1:0] TOT_PAL  = LINE_W'(LINES_PAL);

	logic [LINE_W-1:0] line_q;
	logic [7:0]        hint_down_q;
	logic              parity_q;
	logic              vblank_q;
	logic              vint_seen_q;
	logic              vblank_irq_q;
	logic              hblank_irq_q;
	logic              ext_irq_q;

	logic [LINE_W-1:0] tot;
	logic [LINE_W-1:0] act;
	logic [LINE_W-1:0] line_inc;
	logic [LINE_W-1:0] ln_a;
	logic [LINE_W-1:0] ln_b;
	logic [LINE_W:0]   ivc;
	logic [LINE_W-1:0] vc_wrap;
	logic [VC_W-1:0]   vcount;
	logic [LEVEL_W-1:0] level;

	assign tot      = cfg.pal_mode ? TOT_PAL : TOT_NTSC;
	assign act      = (cfg.tall_mode && cfg.pal_mode) ? ACTIVE_TALL : ACTIVE_SHORT;
	assign line_inc = line_q + 9'd1;

	// Line step, status clear and external latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q       <= '0;
			hint_down_q  <= '0;
			parity_q     <= 1'b0;
			vblank_q     <= 1'b1;
			vint_seen_q  <= 1'b0;
			vblank_irq_q <= 1'b0;
			hblank_irq_q <= 1'b0;
			ext_irq_q    <= 1'b0;
		end else begin
			if (cmd.step) begin
				if (line_q < act) begin
					vblank_q <= 1'b0;
				end else if (line_q == act) begin
					vblank_q    <= 1'b1;
					vint_seen_q <= 1'b1;
					parity_q    <= cfg.interlace ? ~parity_q : 1'b0;
					if (cfg.vint_enable) begin
						vblank_irq_q <= 1'b1;
					end
				end
				// hint down-counter reloads on zero and, when enabled, raises the hblank latch
				if (hint_down_q == 8'd0) begin
					hint_down_q <= cfg.hint_reload;
					if (cfg.hint_enable) begin
						hblank_irq_q <= 1'b1;
					end
				end else begin
					hint_down_q <= hint_down_q - 8'd1;
				end
				// frame wrap
				if (line_inc >= tot) begin
					line_q      <= '0;
					hint_down_q <= cfg.hint_reload;
				end else begin
					line_q <= line_inc;
				end
			end
			if (cmd.status_clear) begin
				vint_seen_q  <= 1'b0;
				vblank_irq_q <= 1'b0;
				hblank_irq_q <= 1'b0;
			end
			if (cmd.ext_set && cfg.ext_enable) begin
				ext_irq_q <= 1'b1;
			end
		end
	end

	// V counter: interlace reads line mod frame length (line below 3 frames)
	assign ln_a    = (line_q >= tot) ? line_q - tot : line_q;
	assign ln_b    = (ln_a >= tot) ? ln_a - tot : ln_a;
	assign ivc     = {ln_b, parity_q};
	assign vc_wrap = line_q - tot;

	always_comb begin
		if (cfg.interlace) begin
			vcount = {ivc[7:1], ivc[8]};
		end else if (line_q <= VC_JUMP) begin
			vcount = line_q[VC_W-1:0];
		end else begin
			vcount = vc_wrap[VC_W-1:0];
		end
	end

	// Priority encode of pending interrupts
	always_comb begin
		if (vblank_irq_q) begin
			level = LEVEL_VBLANK;
		end else if (hblank_irq_q) begin
			level = LEVEL_HBLANK;
		end else if (ext_irq_q) begin
			level = LEVEL_EXT;
		end else begin
			level = LEVEL_NONE;
		end
	end

	assign view.int_level   = level;
	assign view.line_number = line_q;
	assign view.vcount      = vcount;
	assign view.vblank_flag = vblank_q;
	assign view.odd_field   = parity_q;
	assign view.vint_seen   = vint_seen_q;

	// A status read leaves no vblank or hblank latch pending and clears vint_seen
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.status_clear && !cmd.step |=> !vblank_irq_q && !hblank_irq_q && !vint_seen_q)
		else $error("status read did not clear the latches");

	// Without interlace the parity bit stays low after a vblank entry
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && line_q == act && !cfg.interlace |=> !parity_q)
		else $error("parity set outside interlace");

endmodule

@@ hw/rtl/raster_line_timing_irq_top.sv @@
// Top level of the raster line timing and interrupt block: sequencer,
// configuration registers and output register.
// Depends on rlti_pkg, rlti_accum and rlti_raster.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready: s_tuser carries the item kind
//   (advance clocks, status read, external interrupt) and s_tdata the clock
//   count. Each beat yields one result beat on m_tvalid/m_tready with the
//   interrupt level, status word, scanline, V counter and vblank/parity flags.
//   A status read or external interrupt goes from the accept edge straight to
//   the FINISH state; an advance first passes through STEP, where the one
//   compare/subtract unit banks off one whole line a cycle until less than a
//   line is left. FINISH loads the result beat into the output register once
//   that is free and returns to IDLE. s_tready is high only while the
//   sequencer is idle, so one beat is in work at a time. The result sits in
//   an output register; a new beat is taken while it waits, and that beat's
//   result is held back until the receiver takes the previous one, so a
//   stalled receiver stalls the sequencer.
//   Configuration is written through cfg_we/cfg_index/cfg_data; the user must
//   write it only while no beat is in work, the block does not enforce this.
//   Reset clears all registers, enters vblank and leaves the output channel empty.
module raster_line_timing_irq_top #(
	parameter int CLOCKS_PER_LINE = 3420,
	parameter int LINES_NTSC      = 262,
	parameter int LINES_PAL       = 313
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] cycles
	input  logic [1:0]  s_tuser,   // [1:0] op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] int_level, [12:3] status_word, [21:13] line_number,
	// [29:22] vcount, [30] vblank_flag, [31] odd_field
	output logic [31:0] m_tdata
);
	import rlti_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_FINISH
	} state_t;

	state_t              state_q;
	cfg_t                cfg_q;
	logic [STAT_W-1:0]   status_q;
	logic                m_tvalid_q;
	logic [31:0]         m_tdata_q;

	logic                accept;
	logic                line_due;
	logic                do_step;
	logic                out_free;
	logic [STAT_W-1:0]   status_now;
	raster_cmd_t         cmd;
	raster_view_t        view;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign do_step  = (state_q == ST_STEP) && line_due;
	assign out_free = !m_tvalid_q || m_tready;

	assign cmd.step         = do_step;
	assign cmd.status_clear = accept && (s_tuser == OP_STATUS);
	assign cmd.ext_set      = accept && (s_tuser == OP_EXT);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HINT_RELOAD: cfg_q.hint_reload    <= cfg_data;
				REG_HINT_EN:     cfg_q.hint_enable    <= cfg_data[0];
				REG_VINT_EN:     cfg_q.vint_enable    <= cfg_data[0];
				REG_EXT_EN:      cfg_q.ext_enable     <= cfg_data[0];
				REG_DISP_EN:     cfg_q.display_enable <= cfg_data[0];
				REG_PAL:         cfg_q.pal_mode       <= cfg_data[0];
				REG_TALL:        cfg_q.tall_mode      <= cfg_data[0];
				REG_INTERLACE:   cfg_q.interlace      <= cfg_data[0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// Status word as seen before the read clears the latches
	always_comb begin
		status_now                = '0;
		status_now[ST_FIFO_EMPTY] = 1'b1;
		status_now[ST_VINT_SEEN]  = view.vint_seen;
		status_now[ST_ODD]        = view.odd_field;
		status_now[ST_VBLANK]     = view.vblank_flag || !cfg_q.display_enable;
		status_now[ST_PAL]        = cfg_q.pal_mode;
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			status_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q <= (s_tuser == OP_STATUS) ? status_now : '0;
						state_q  <= (s_tuser == OP_ADVANCE) ? ST_STEP : ST_FINISH;
					end
				end
				ST_STEP: begin
					if (!line_due) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {view.odd_field, view.vblank_flag, view.vcount,
							view.line_number, status_q, view.int_level};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	rlti_accum #(
		.CLOCKS_PER_LINE(CLOCKS_PER_LINE)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.add     (accept && (s_tuser == OP_ADVANCE)),
		.cycles  (s_tdata),
		.sub     (do_step),
		.line_due(line_due)
	);

	rlti_raster #(
		.LINES_NTSC(LINES_NTSC),
		.LINES_PAL (LINES_PAL)
	) u_raster (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.cmd   (cmd),
		.view  (view)
	);

	// Idle means no whole line is left in the bank
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !line_due)
		else $error("sequencer idle with a line still banked");

	// A finishing beat with a free output always produces a result
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && out_free |=> m_tvalid && state_q == ST_IDLE)
		else $error("finished beat did not reach the output register");

	// Only one beat in work: after an accept the input side closes
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second beat accepted while one is in work");

endmodule
